@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and helpers of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int MaxWidth = 32;
    localparam int DvdW     = 2 * MaxWidth - 1;
    localparam int RemW     = MaxWidth + 1;
    localparam int ProdW    = 2 * MaxWidth;
    localparam int DivSteps = DvdW;
    localparam int IntW     = 6;
    localparam int FracW    = 5;
    localparam int ReqW     = 3;
    localparam int CfgIdxW  = 1;
    localparam int CfgW     = 6;

    localparam logic [IntW-1:0]  IntBitsRst  = IntW'(16);
    localparam logic [FracW-1:0] FracBitsRst = FracW'(16);

    typedef enum logic [ReqW-1:0] {
        REQ_ADD  = 3'd0,
        REQ_SUB  = 3'd1,
        REQ_MUL  = 3'd2,
        REQ_DIV  = 3'd3,
        REQ_PASS = 3'd4
    } t_req;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INT_BITS  = 1'd0,
        CFG_FRAC_BITS = 1'd1
    } t_cfg_idx;

    // One item in flight through the divider chain
    typedef struct packed {
        logic                valid;
        t_req                op;
        logic                sneg;
        logic                dz;
        logic [MaxWidth-1:0] mask;
        logic [MaxWidth-1:0] res;
        logic [MaxWidth-1:0] dsr;
        logic [RemW-1:0]     rem;
        logic [DvdW-1:0]     dvd;
        logic [MaxWidth-1:0] quo;
    } t_item;

    // Two's complement negate within the active width
    function automatic logic [MaxWidth-1:0] neg_w(input logic [MaxWidth-1:0] v,
                                                  input logic [MaxWidth-1:0] m);
        neg_w = (~v + MaxWidth'(1)) & m;
    endfunction

endpackage

@@ rtl/fpa_if.sv @@
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface fpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [fpa_pkg::ReqW-1:0]     req_type;
    logic [fpa_pkg::MaxWidth-1:0] operand_a;
    logic [fpa_pkg::MaxWidth-1:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fpa_pkg::MaxWidth-1:0] result;
    logic                         div_by_zero;

    modport source (output valid, result, div_by_zero, input ready);
    modport sink   (input valid, result, div_by_zero, output ready);
endinterface

@@ rtl/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: add, subtract, multiply, divide, pass.
// ----------------------------------------------------------------------------
// Every request takes the same fixed path from transfer in to
// result valid: one masking stage, one stage for magnitudes and the 32x32
// multiply, 63 restoring-division stages (one quotient bit each, set by the
// up to 63-bit scaled dividend), and the output register. A new request is
// taken in every cycle; the whole pipe advances together and holds only
// while a finished result waits on the output. The format (int_bits,
// frac_bits) is read from the configuration registers at transfer in; change
// it only with the pipe empty.
module fixed_point_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpa_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [fpa_pkg::CfgW-1:0]      i_cfg_wdata,
    fpa_req_if.sink                       i_req,
    fpa_rsp_if.source                     o_rsp
);

    // Configuration registers
    logic [fpa_pkg::IntW-1:0]  r_int_bits;
    logic [fpa_pkg::FracW-1:0] r_frac_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_bits  <= fpa_pkg::IntBitsRst;
            r_frac_bits <= fpa_pkg::FracBitsRst;
        end else if (i_cfg_we) begin
            case (fpa_pkg::t_cfg_idx'(i_cfg_idx))
                fpa_pkg::CFG_INT_BITS:  r_int_bits  <= i_cfg_wdata[fpa_pkg::IntW-1:0];
                fpa_pkg::CFG_FRAC_BITS: r_frac_bits <= i_cfg_wdata[fpa_pkg::FracW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the format: A in 1..32, B at most 32 - A
    logic [fpa_pkg::IntW-1:0]     a_eff, b_room, w_eff;
    logic [fpa_pkg::FracW-1:0]    b_eff;
    logic [fpa_pkg::MaxWidth-1:0] w_mask;

    always_comb begin
        if (r_int_bits == '0) begin
            a_eff = fpa_pkg::IntW'(1);
        end else if (r_int_bits > fpa_pkg::IntW'(fpa_pkg::MaxWidth)) begin
            a_eff = fpa_pkg::IntW'(fpa_pkg::MaxWidth);
        end else begin
            a_eff = r_int_bits;
        end
        b_room = fpa_pkg::IntW'(fpa_pkg::MaxWidth) - a_eff;
        b_eff  = (fpa_pkg::IntW'(r_frac_bits) > b_room) ?
                 b_room[fpa_pkg::FracW-1:0] : r_frac_bits;
        w_eff  = a_eff + fpa_pkg::IntW'(b_eff);
        w_mask = {fpa_pkg::MaxWidth{1'b1}} >> (fpa_pkg::IntW'(fpa_pkg::MaxWidth) - w_eff);
    end

    // Global advance: move everything unless a result is held on the output
    logic r_out_valid;
    logic en;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    fpa_pkg::t_item chain [fpa_pkg::DivSteps+1];

    fpa_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_a        (i_req.operand_a),
        .i_b        (i_req.operand_b),
        .i_mask     (w_mask),
        .i_frac     (b_eff),
        .o_item     (chain[0])
    );

    // Divider pipe; every item flows through it to keep order and latency
    for (genvar g = 0; g < fpa_pkg::DivSteps; g++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (chain[g]),
            .o_item  (chain[g+1])
        );
    end

    // Final select: quotient for divides, carried result otherwise
    fpa_pkg::t_item               last;
    logic [fpa_pkg::MaxWidth-1:0] q_m, n_out_res;

    always_comb begin
        last = chain[fpa_pkg::DivSteps];
        q_m  = last.quo & last.mask;
        if (last.op == fpa_pkg::REQ_DIV) begin
            if (last.dz) begin
                n_out_res = '0;
            end else begin
                n_out_res = last.sneg ? fpa_pkg::neg_w(q_m, last.mask) : q_m;
            end
        end else begin
            n_out_res = last.res;
        end
    end

    // Output register: hold until the sink takes the transfer
    logic [fpa_pkg::MaxWidth-1:0] r_out_res;
    logic                         r_out_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
        if (en) begin
            r_out_res <= n_out_res;
            r_out_dz  <= last.dz;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result      = r_out_res;
    assign o_rsp.div_by_zero = r_out_dz;

    // A divide-by-zero result is always zero
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dz |-> r_out_res == '0)
        else $error("div_by_zero with nonzero result");

    // Upper bits above the active width stay clear
    a_upper_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_res & ~w_mask) == '0)
        else $error("result bits above width set");

    // An accepted request enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && en |=> u_prep.r_a_valid)
        else $error("accepted request lost");

    // A stalled output holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_out_res))
        else $error("stalled result changed");

endmodule

@@ rtl/fpa_prep.sv @@
// ----------------------------------------------------------------------------
// fpa_prep
// Operand masking, magnitudes, add/sub/pass, and the registered multiplier.
// ----------------------------------------------------------------------------
module fpa_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [fpa_pkg::ReqW-1:0]      i_req_type,
    input  logic [fpa_pkg::MaxWidth-1:0]  i_a,
    input  logic [fpa_pkg::MaxWidth-1:0]  i_b,
    input  logic [fpa_pkg::MaxWidth-1:0]  i_mask,
    input  logic [fpa_pkg::FracW-1:0]     i_frac,
    output fpa_pkg::t_item                o_item
);

    // stage A: masked operands
    logic                         r_a_valid;
    fpa_pkg::t_req                r_a_op;
    logic [fpa_pkg::MaxWidth-1:0] r_a_x, r_a_y, r_a_mask;
    logic [fpa_pkg::FracW-1:0]    r_a_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_op   <= fpa_pkg::t_req'(i_req_type);
            r_a_x    <= i_a & i_mask;
            r_a_y    <= i_b & i_mask;
            r_a_mask <= i_mask;
            r_a_frac <= i_frac;
        end
    end

    // stage B: magnitudes, product, dividend
    logic [fpa_pkg::MaxWidth-1:0] sbit, mx, my;
    logic                         sx, sy;
    fpa_pkg::t_item               n_b;

    always_comb begin
        sbit = r_a_mask ^ (r_a_mask >> 1);
        sx   = |(r_a_x & sbit);
        sy   = |(r_a_y & sbit);
        mx   = sx ? fpa_pkg::neg_w(r_a_x, r_a_mask) : r_a_x;
        my   = sy ? fpa_pkg::neg_w(r_a_y, r_a_mask) : r_a_y;
        n_b       = '0;
        n_b.valid = r_a_valid;
        n_b.op    = r_a_op;
        n_b.sneg  = sx ^ sy;
        n_b.mask  = r_a_mask;
        n_b.dsr   = my;
        n_b.dvd   = fpa_pkg::DvdW'(mx) << r_a_frac;
        n_b.dz    = (r_a_op == fpa_pkg::REQ_DIV) && (r_a_y == '0);
        case (r_a_op)
            fpa_pkg::REQ_ADD:  n_b.res = (r_a_x + r_a_y) & r_a_mask;
            fpa_pkg::REQ_SUB:  n_b.res = (r_a_x - r_a_y) & r_a_mask;
            fpa_pkg::REQ_PASS: n_b.res = r_a_x;
            default:           n_b.res = '0;
        endcase
    end

    fpa_pkg::t_item            r_b;
    logic [fpa_pkg::ProdW-1:0] r_b_prod;
    logic [fpa_pkg::FracW-1:0] r_b_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b.valid <= n_b.valid;
        end
        if (i_en) begin
            r_b.op   <= n_b.op;
            r_b.sneg <= n_b.sneg;
            r_b.dz   <= n_b.dz;
            r_b.mask <= n_b.mask;
            r_b.res  <= n_b.res;
            r_b.dsr  <= n_b.dsr;
            r_b.rem  <= n_b.rem;
            r_b.dvd  <= n_b.dvd;
            r_b.quo  <= n_b.quo;
            r_b_prod <= fpa_pkg::ProdW'(mx) * fpa_pkg::ProdW'(my);
            r_b_frac <= r_a_frac;
        end
    end

    // scale the product and apply the sign
    logic [fpa_pkg::MaxWidth-1:0] prod_sc;

    always_comb begin
        prod_sc = fpa_pkg::MaxWidth'(r_b_prod >> r_b_frac) & r_b.mask;
        o_item  = r_b;
        if (r_b.op == fpa_pkg::REQ_MUL) begin
            o_item.res = r_b.sneg ? fpa_pkg::neg_w(prod_sc, r_b.mask) : prod_sc;
        end
    end

endmodule

@@ rtl/fpa_div_step.sv @@
// ----------------------------------------------------------------------------
// fpa_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fpa_pkg::t_item i_item,
    output fpa_pkg::t_item o_item
);

    logic [fpa_pkg::RemW-1:0] rem_sh, dsr_x;
    logic                     ge;
    fpa_pkg::t_item           n_item;
    fpa_pkg::t_item           r_item;

    always_comb begin
        rem_sh     = {i_item.rem[fpa_pkg::RemW-2:0], i_item.dvd[fpa_pkg::DvdW-1]};
        dsr_x      = fpa_pkg::RemW'(i_item.dsr);
        ge         = rem_sh >= dsr_x;
        n_item     = i_item;
        n_item.rem = ge ? (rem_sh - dsr_x) : rem_sh;
        n_item.dvd = i_item.dvd << 1;
        n_item.quo = {i_item.quo[fpa_pkg::MaxWidth-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item.valid <= n_item.valid;
        end
        if (i_en) begin
            r_item.op   <= n_item.op;
            r_item.sneg <= n_item.sneg;
            r_item.dz   <= n_item.dz;
            r_item.mask <= n_item.mask;
            r_item.res  <= n_item.res;
            r_item.dsr  <= n_item.dsr;
            r_item.rem  <= n_item.rem;
            r_item.dvd  <= n_item.dvd;
            r_item.quo  <= n_item.quo;
        end
    end

    assign o_item = r_item;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the fixed-point ALU: directed corner cases in several
// formats, random requests over several formats, with random stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] result;
        logic        dz;
    } t_alu_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [fpa_pkg::CfgIdxW-1:0] i_cfg_idx;
    logic [fpa_pkg::CfgW-1:0]    i_cfg_wdata;

    fpa_req_if req_ch ();
    fpa_rsp_if rsp_ch ();

    fixed_point_alu u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // Shadow copy of the format registers
    logic [5:0] int_bits_q  = 6'd16;
    logic [4:0] frac_bits_q = 5'd16;

    t_alu_out alu_expected_q[$];
    int       mismatch_cnt = 0;
    int       result_cnt   = 0;
    int       req_cnt      = 0;
    bit       idle_en      = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Compute one result from the current format, in 64-bit arithmetic
    function automatic t_alu_out alu_predict(input logic [2:0] op,
                                             input logic [31:0] a_raw,
                                             input logic [31:0] b_raw);
        int unsigned ia, fb, w;
        logic [63:0] m, x, y, mx, my, r;
        logic        sx, sy;
        t_alu_out    o;
        ia = int_bits_q;
        fb = frac_bits_q;
        if (ia < 1) ia = 1;
        if (ia > 32) ia = 32;
        if (fb > 32 - ia) fb = 32 - ia;
        w = ia + fb;
        m = (64'd1 << w) - 64'd1;
        x = {32'd0, a_raw} & m;
        y = {32'd0, b_raw} & m;
        r = '0;
        o.dz = 1'b0;
        sx = x[w-1];
        sy = y[w-1];
        mx = sx ? ((~x + 64'd1) & m) : x;
        my = sy ? ((~y + 64'd1) & m) : y;
        case (op)
            fpa_pkg::REQ_ADD: r = (x + y) & m;
            fpa_pkg::REQ_SUB: r = (x - y) & m;
            fpa_pkg::REQ_MUL: r = ((mx * my) >> fb) & m;
            fpa_pkg::REQ_DIV: begin
                if (y == 0) o.dz = 1'b1;
                else r = ((mx << fb) / my) & m;
            end
            fpa_pkg::REQ_PASS: r = x;
            default: r = '0;
        endcase
        // apply the sign of the product or quotient
        if ((op == fpa_pkg::REQ_MUL || op == fpa_pkg::REQ_DIV) && !o.dz && sx != sy)
            r = (~r + 64'd1) & m;
        o.result = r[31:0];
        return o;
    endfunction

    // Drive one register write; the caller drops the write enable afterwards
    task automatic write_reg(input fpa_pkg::t_cfg_idx idx, input logic [5:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == fpa_pkg::CFG_INT_BITS) int_bits_q = val;
        else frac_bits_q = val[4:0];
    endtask

    // Drain the pipe, then change the format
    task automatic set_format(input logic [5:0] ib, input logic [5:0] fb);
        wait_drain();
        write_reg(fpa_pkg::CFG_INT_BITS, ib);
        write_reg(fpa_pkg::CFG_FRAC_BITS, fb);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (alu_expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Send one request; hold valid until the transfer happens
    task automatic send_req(input logic [2:0] op, input logic [31:0] a,
                            input logic [31:0] b);
        while (idle_en && $urandom_range(99) < 9) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        alu_expected_q.push_back(alu_predict(op, a, b));
        req_cnt++;
    endtask

    // Result side: random back-pressure, compare with the oldest expectation
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                t_alu_out exp_v;
                if (alu_expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %h dz %b",
                                 rsp_ch.result, rsp_ch.div_by_zero);
                end else begin
                    exp_v = alu_expected_q.pop_front();
                    result_cnt++;
                    if (exp_v.result !== rsp_ch.result
                        || exp_v.dz !== rsp_ch.div_by_zero) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp %h/%b got %h/%b",
                                     exp_v.result, exp_v.dz,
                                     rsp_ch.result, rsp_ch.div_by_zero);
                    end
                end
            end
            rsp_ch.ready <= !(idle_en && $urandom_range(99) < 9);
        end
    end

    // Extreme operand values for every request code, then fixed corner cases, under the current format
    task automatic test_directed();
        logic [31:0] vals[6];
        vals = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0001_0000, 32'h0000_0001};
        for (int op = 0; op < 8; op++) begin
            send_req(op[2:0], vals[$urandom_range(5)], vals[$urandom_range(5)]);
        end
        send_req(fpa_pkg::REQ_DIV, 32'h1234_5678, 32'h0);
        send_req(fpa_pkg::REQ_MUL, 32'h8000_0000, 32'h8000_0000);
        send_req(fpa_pkg::REQ_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_req(fpa_pkg::REQ_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_req(fpa_pkg::REQ_SUB, 32'h0, 32'hFFFF_FFFF);
        send_req(fpa_pkg::REQ_PASS, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            logic [2:0] op;
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4));
            send_req(op, rand_operand(), ($urandom_range(9) == 0) ? 32'h0
                                                                  : rand_operand());
        end
    endtask

    // Random requests with the random stalls turned off, so the pipe can stream one transfer per cycle
    task automatic test_streaming();
        idle_en = 1'b0;
        test_random(60);
        idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= fpa_pkg::CFG_INT_BITS;
        i_cfg_wdata      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= fpa_pkg::REQ_ADD;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset format Q16.16
        test_directed();
        test_random(100);
        test_streaming();
        // Sweep formats: zero int bits, oversize int bits, clamped fraction
        set_format(6'd0, 6'd0);   test_directed(); test_random(40);
        set_format(6'd63, 6'd31); test_directed(); test_random(60);
        set_format(6'd32, 6'd0);  test_random(60);
        set_format(6'd1, 6'd31);  test_directed(); test_random(60);
        set_format(6'd20, 6'd31); test_random(60);
        set_format(6'd8, 6'd4);   test_directed(); test_random(60);
        set_format(6'd3, 6'd0);   test_random(40);
        set_format(6'($urandom_range(32, 1)), 6'($urandom_range(31)));
        test_random(80);

        wait_drain();
        $display("covered %0d requests and %0d results over nine formats",
                 req_cnt, result_cnt);
        if (mismatch_cnt == 0 && alu_expected_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     alu_expected_q.size());
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("testbench: errors");
        $finish;
    end
endmodule

@@ fixed_point_alu.f @@
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_prep.sv
rtl/fpa_div_step.sv
rtl/fixed_point_alu.sv
tb/testbench.sv
